// ===== hw/rtl/vsld_pkg.sv =====
// types and constants shared by the voxel store with column light depth
// no dependencies; compiled first
`default_nettype none

package vsld_pkg;

    // command carried on the input tuser bit
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // the one tile code that counts as solid
    localparam logic [7:0] TILE_SOLID = 8'd1;
    localparam logic [7:0] TILE_EMPTY = 8'd0;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_LOOK,
        ST_WRITE,
        ST_SCAN,
        ST_RESULT
    } state_t;

    // result item; last member sits in the lowest bits
    typedef struct packed {
        logic       tile_written;
        logic [5:0] span_high;
        logic [5:0] span_low;
        logic       column_changed;
        logic       is_dark;
        logic       is_solid;
        logic [7:0] tile_value;
        logic       in_bounds;
    } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/voxel_store_column_light_depth.sv =====
// a read looks the tile up and then loads its result; an out of grid item goes straight
// to the result; a write stores the tile, then rescans the column (one level per cycle
// from the top down to the first solid level, or to level 1 if none is found, through
// the single read port of the tile ram) before its result. one item at a time; the next
// is taken at idle, once the result has been loaded into the output register.
// reset: control clears at once, then a fill pass writes the tile and depth
// rams one entry per cycle over all 2**(clog2(SIZE_Y)+clog2(SIZE_Z)+clog2(SIZE_X))
// tile addresses (262144 at 64x64x64), with s_axis_tready low throughout.
// top level; depends on vsld_pkg and vsld_ram
`default_nettype none

module voxel_store_column_light_depth #(
    parameter int SIZE_X = 64,
    parameter int SIZE_Z = 64,
    parameter int SIZE_Y = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // pos_x[7:0], pos_y[15:8], pos_z[23:16], tile_type[31:24]
    input  wire logic [31:0] s_axis_tdata,
    // cmd[0]
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // in_bounds[0], tile_value[8:1], is_solid[9], is_dark[10], column_changed[11],
    // span_low[17:12], span_high[23:18], tile_written[24], zero[31:25]
    output logic      [31:0] m_axis_tdata
);

    import vsld_pkg::*;

    localparam int XW       = $clog2(SIZE_X);
    localparam int ZW       = $clog2(SIZE_Z);
    localparam int YW       = $clog2(SIZE_Y);
    localparam int CAW      = ZW + XW;
    localparam int TAW      = YW + CAW;
    localparam int FILL_TOP = (SIZE_Y * 2) / 3;

    localparam logic [8:0]    SX9      = 9'(SIZE_X);
    localparam logic [8:0]    SY9      = 9'(SIZE_Y);
    localparam logic [8:0]    SZ9      = 9'(SIZE_Z);
    localparam logic [YW-1:0] FILL_D   = YW'(FILL_TOP);
    localparam logic [YW-1:0] TOP_Y    = YW'(SIZE_Y - 1);
    localparam logic [YW-1:0] Y_ONE    = YW'(1);

    state_t state_reg, state_next;

    // control registers
    logic [TAW-1:0] init_cnt_reg;
    logic           chk_valid_reg;
    logic           out_valid_reg;

    // payload registers
    logic           cmd_reg;
    logic [XW-1:0]  x_reg;
    logic [YW-1:0]  y_reg;
    logic [ZW-1:0]  z_reg;
    logic [7:0]     code_reg;
    logic [YW-1:0]  old_d_reg;
    logic [YW-1:0]  scan_y_reg;
    logic [YW-1:0]  chk_y_reg;
    result_t        res_reg;
    result_t        out_reg;

    // input decode
    logic [7:0] in_x, in_y, in_z;
    logic       in_inb;
    logic       accept;

    // ram ports
    logic           t_we, c_we;
    logic [TAW-1:0] t_waddr, t_raddr;
    logic [CAW-1:0] c_waddr, c_raddr;
    logic [7:0]     t_wdata, t_rdata;
    logic [YW-1:0]  c_wdata, c_rdata;

    // scan and result
    logic           scan_hit, scan_end;
    logic [YW-1:0]  new_d, span_lo, span_hi;
    logic           load_out;
    logic [YW-1:0]  init_y;
    logic [TAW-1:0] cur_addr;
    logic [CAW-1:0] cur_col;

    assign in_x   = s_axis_tdata[7:0];
    assign in_y   = s_axis_tdata[15:8];
    assign in_z   = s_axis_tdata[23:16];
    // sign bit clear and below the grid edge
    assign in_inb = !in_x[7] && ({1'b0, in_x} < SX9)
                 && !in_y[7] && ({1'b0, in_y} < SY9)
                 && !in_z[7] && ({1'b0, in_z} < SZ9);
    assign accept = s_axis_tvalid && s_axis_tready;

    assign init_y   = init_cnt_reg[TAW-1 -: YW];
    assign cur_col  = {z_reg, x_reg};
    assign cur_addr = {y_reg, z_reg, x_reg};

    // pipelined scan: address issued one cycle, code checked the next
    assign scan_hit = chk_valid_reg && (t_rdata == TILE_SOLID);
    assign scan_end = chk_valid_reg && (scan_hit || (chk_y_reg == Y_ONE));
    assign new_d    = scan_hit ? chk_y_reg : '0;
    assign span_lo  = (old_d_reg < new_d) ? old_d_reg : new_d;
    assign span_hi  = (old_d_reg < new_d) ? new_d : old_d_reg;

    vsld_ram #(
        .WIDTH (8),
        .DEPTH (2 ** TAW)
    ) u_tile_ram (
        .clk   (clk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    vsld_ram #(
        .WIDTH (YW),
        .DEPTH (2 ** CAW)
    ) u_depth_ram (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (init_cnt_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!in_inb)
                    begin
                        state_next = ST_RESULT;
                    end
                    else if (s_axis_tuser == CMD_WRITE)
                    begin
                        state_next = ST_WRITE;
                    end
                    else
                    begin
                        state_next = ST_LOOK;
                    end
                end
            end
            ST_LOOK:   state_next = ST_RESULT;
            ST_WRITE:  state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_INIT;
        endcase
    end

    // control outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        load_out      = 1'b0;
        t_we          = 1'b0;
        t_waddr       = cur_addr;
        t_wdata       = code_reg;
        t_raddr       = {scan_y_reg, z_reg, x_reg};
        c_we          = 1'b0;
        c_waddr       = cur_col;
        c_wdata       = new_d;
        c_raddr       = {in_z[ZW-1:0], in_x[XW-1:0]};
        unique case (state_reg)
            ST_INIT:
            begin
                t_we    = 1'b1;
                t_waddr = init_cnt_reg;
                t_wdata = (init_y <= FILL_D) ? TILE_SOLID : TILE_EMPTY;
                c_we    = (init_y == '0);
                c_waddr = init_cnt_reg[CAW-1:0];
                c_wdata = FILL_D;
            end
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                t_raddr       = {in_y[YW-1:0], in_z[ZW-1:0], in_x[XW-1:0]};
            end
            ST_WRITE:
            begin
                t_we = 1'b1;
            end
            ST_SCAN:
            begin
                c_we = scan_end;
            end
            ST_RESULT:
            begin
                load_out = !out_valid_reg || m_axis_tready;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            init_cnt_reg  <= '0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_INIT)
            begin
                init_cnt_reg <= init_cnt_reg + 1'b1;
            end
            chk_valid_reg <= (state_reg == ST_SCAN) && !scan_end;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= s_axis_tuser;
            x_reg    <= in_x[XW-1:0];
            y_reg    <= in_y[YW-1:0];
            z_reg    <= in_z[ZW-1:0];
            code_reg <= s_axis_tdata[31:24];
            res_reg  <= '0;
        end
        // write fields stay at the zero loaded on the transfer
        if (state_reg == ST_LOOK)
        begin
            res_reg.in_bounds  <= 1'b1;
            res_reg.tile_value <= t_rdata;
            res_reg.is_solid   <= (t_rdata == TILE_SOLID);
            res_reg.is_dark    <= (y_reg < c_rdata);
        end
        if (state_reg == ST_WRITE)
        begin
            old_d_reg  <= c_rdata;
            scan_y_reg <= TOP_Y;
        end
        if (state_reg == ST_SCAN)
        begin
            scan_y_reg <= scan_y_reg - 1'b1;
            chk_y_reg  <= scan_y_reg;
            if (scan_end)
            begin
                res_reg.in_bounds      <= 1'b1;
                res_reg.tile_value     <= code_reg;
                res_reg.is_solid       <= (code_reg == TILE_SOLID);
                res_reg.is_dark        <= (y_reg < new_d);
                res_reg.column_changed <= (old_d_reg != new_d);
                res_reg.span_low       <= (old_d_reg != new_d) ? 6'(span_lo) : 6'd0;
                res_reg.span_high      <= (old_d_reg != new_d) ? 6'(span_hi) : 6'd0;
                res_reg.tile_written   <= (cmd_reg == CMD_WRITE);
            end
        end
        if (load_out)
        begin
            out_reg <= res_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_reg};

    // rams are written only by the fill pass, the tile store step and the scan end
    a_tile_we_state: assert property (@(posedge clk) disable iff (!rst_n)
        t_we |-> (state_reg == ST_INIT || state_reg == ST_WRITE))
        else $error("tile ram written outside fill or store");

    a_depth_we_state: assert property (@(posedge clk) disable iff (!rst_n)
        c_we |-> (state_reg == ST_INIT || (state_reg == ST_SCAN && scan_end)))
        else $error("depth ram written outside fill or scan end");

    a_no_result_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INIT) |-> (!m_axis_tvalid && !s_axis_tready))
        else $error("handshake active during fill pass");

    a_change_needs_write: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_reg.column_changed)
            |-> (out_reg.tile_written && out_reg.in_bounds))
        else $error("column change reported without a stored write");

endmodule

`default_nettype wire

// ===== hw/rtl/vsld_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module vsld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
